// ===== rtl/core/nfrag_pkg.sv =====
// nfrag_pkg: shared types and constants of the notification packet fragmenter.
// No dependencies; imported by every module under rtl/core.
package nfrag_pkg;

  localparam int unsigned MTU_W    = 10;
  localparam int unsigned MIN_MTU  = 23;
  localparam int unsigned HDR_LEN  = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned NSLOTS   = 4;
  localparam int unsigned SLOT_W   = 2;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 3;

  // register indexes (byte address is 4 * index)
  localparam logic REG_LINK_MTU = 1'b0;

  // output slots: three header bytes, then the payload byte
  localparam logic [SLOT_W-1:0] SLOT_PN_LO   = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_PAYLOAD = 2'd3;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    byte_t [NSLOTS-1:0] bytes;  // slot 3 is the payload byte
    logic               hdr;    // packet opens with this byte
    logic               close;  // payload byte ends the packet
  } nfrag_bundle_t;

endpackage

// ===== rtl/core/nfrag_cfg.sv =====
// nfrag_cfg: APB register file holding link_mtu and the derived payload limit.
// Depends on nfrag_pkg.
module nfrag_cfg #(
  parameter int unsigned MAX_MTU = 517,
  parameter int unsigned LIM_W   = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nfrag_pkg::APB_AW-1:0]  paddr,
  input  logic [nfrag_pkg::APB_DW-1:0]  pwdata,
  output logic [nfrag_pkg::APB_DW-1:0]  prdata,
  output logic                          pready,
  output logic [LIM_W-1:0]              limit_o
);
  import nfrag_pkg::*;

  localparam logic [LIM_W-1:0] MinMtu = LIM_W'(MIN_MTU);
  localparam logic [LIM_W-1:0] MaxMtu = LIM_W'(MAX_MTU);
  localparam logic [LIM_W-1:0] HdrLen = LIM_W'(HDR_LEN);

  logic [MTU_W-1:0] mtu_q, mtu_d;
  logic             sel_mtu;
  logic [LIM_W-1:0] mtu_ext, mtu_sat;

  assign pready  = 1'b1;
  assign sel_mtu = (paddr[APB_AW-1] == REG_LINK_MTU);

  always_comb begin
    mtu_d = mtu_q;
    if (psel && penable && pwrite && sel_mtu) begin
      mtu_d = pwdata[MTU_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q <= MTU_W'(MIN_MTU);
    end else begin
      mtu_q <= mtu_d;
    end
  end

  assign prdata = sel_mtu ? APB_DW'(mtu_q) : '0;

  // saturate into [MIN_MTU, MAX_MTU], then drop the header length
  always_comb begin
    mtu_ext = LIM_W'(mtu_q);
    if (mtu_ext < MinMtu) begin
      mtu_sat = MinMtu;
    end else if (mtu_ext > MaxMtu) begin
      mtu_sat = MaxMtu;
    end else begin
      mtu_sat = mtu_ext;
    end
    limit_o = mtu_sat - HdrLen;
  end

endmodule

// ===== rtl/core/nfrag_core.sv =====
// nfrag_core: input register and packet/chunk/fill state; builds one output bundle per byte.
// Depends on nfrag_pkg.
module nfrag_core #(
  parameter int unsigned LIM_W = 11
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  nfrag_pkg::byte_t         data_byte_i,
  input  logic                     frame_last_i,
  input  logic [LIM_W-1:0]         limit_i,
  input  logic                     load_ok_i,
  output logic                     load_o,
  output nfrag_pkg::nfrag_bundle_t bundle_o
);
  import nfrag_pkg::*;

  logic             s1_vld_q, s1_vld_d;
  byte_t            s1_byte_q;
  logic             s1_last_q;
  logic             accept;
  logic [15:0]      pkt_num_q, pkt_num_d;
  logic [7:0]       chunk_q, chunk_d;
  logic [MTU_W-1:0] fill_q, fill_d, fill_inc;
  logic             hdr, close;

  assign in_stall_o = s1_vld_q && !load_ok_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign load_o     = s1_vld_q && load_ok_i;

  assign hdr      = (fill_q == '0);
  assign fill_inc = fill_q + MTU_W'(1);
  assign close    = s1_last_q || (LIM_W'(fill_inc) >= limit_i);

  always_comb begin
    bundle_o.bytes[0]            = pkt_num_q[7:0];
    bundle_o.bytes[1]            = pkt_num_q[15:8];
    bundle_o.bytes[2]            = chunk_q;
    bundle_o.bytes[SLOT_PAYLOAD] = s1_byte_q;
    bundle_o.hdr                 = hdr;
    bundle_o.close               = close;
  end

  always_comb begin
    s1_vld_d  = s1_vld_q;
    pkt_num_d = pkt_num_q;
    chunk_d   = chunk_q;
    fill_d    = fill_q;
    if (load_o) begin
      s1_vld_d = 1'b0;
      if (hdr) begin
        pkt_num_d = pkt_num_q + 16'd1;
      end
      if (close) begin
        fill_d  = '0;
        chunk_d = s1_last_q ? 8'd0 : chunk_q + 8'd1;
      end else begin
        fill_d = fill_inc;
      end
    end
    if (accept) begin
      s1_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      pkt_num_q <= '0;
      chunk_q   <= '0;
      fill_q    <= '0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      pkt_num_q <= pkt_num_d;
      chunk_q   <= chunk_d;
      fill_q    <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= frame_last_i;
    end
  end

endmodule

// ===== rtl/core/nfrag_out.sv =====
// nfrag_out: result register; sends a bundle out one byte per transaction.
// Depends on nfrag_pkg.
module nfrag_out (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  nfrag_pkg::nfrag_bundle_t bundle_i,
  output logic                     load_ok_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output nfrag_pkg::byte_t         out_byte_o,
  output logic                     is_header_o,
  output logic                     packet_end_o,
  output logic                     run_last_o
);
  import nfrag_pkg::*;

  nfrag_bundle_t     bun_q;
  logic              vld_q, vld_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic              take, at_payload;

  assign at_payload = (idx_q == SLOT_PAYLOAD);
  assign take       = vld_q && !out_stall_i;
  assign load_ok_o  = !vld_q || (take && at_payload);

  always_comb begin
    vld_d = vld_q;
    idx_d = idx_q;
    if (load_i) begin
      vld_d = 1'b1;
      idx_d = bundle_i.hdr ? SLOT_PN_LO : SLOT_PAYLOAD;
    end else if (take) begin
      if (at_payload) begin
        vld_d = 1'b0;
      end else begin
        idx_d = idx_q + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= SLOT_PAYLOAD;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bun_q <= bundle_i;
    end
  end

  assign out_valid_o  = vld_q;
  assign out_byte_o   = bun_q.bytes[idx_q];
  assign is_header_o  = !at_payload;
  assign packet_end_o = at_payload && bun_q.close;
  assign run_last_o   = at_payload;

endmodule

// ===== rtl/core/notify_packet_fragmenter.sv =====
// Notification packet fragmenter. Payload bytes of a frame enter one per transaction and leave
// as packets of at most link_mtu - 3 payload bytes, each opened by a 3-byte header (packet
// number low, packet number high, chunk number). A byte that opens a packet leaves after its
// three header bytes, since they share the single output register. An input register and
// the output register let the next byte be taken while the current result waits. A byte
// passes through the input register and then the output register.
// link_mtu is read through APB at address 0 and saturated into [23, MAX_MTU].
module notify_packet_fragmenter #(
  parameter int unsigned MAX_MTU = 517
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nfrag_pkg::APB_AW-1:0]  paddr,
  input  logic [nfrag_pkg::APB_DW-1:0]  pwdata,
  output logic [nfrag_pkg::APB_DW-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          frame_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_byte_o,
  output logic                          is_header_o,
  output logic                          packet_end_o,
  output logic                          run_last_o
);
  import nfrag_pkg::*;

  localparam int unsigned MaxW  = $clog2(MAX_MTU + 1);
  localparam int unsigned LimW  = (MaxW > MTU_W) ? MaxW : MTU_W;

  logic [LimW-1:0] limit;
  logic            load, load_ok;
  nfrag_bundle_t   bundle;

  nfrag_cfg #(
    .MAX_MTU (MAX_MTU),
    .LIM_W   (LimW)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  nfrag_core #(
    .LIM_W (LimW)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .frame_last_i (frame_last_i),
    .limit_i      (limit),
    .load_ok_i    (load_ok),
    .load_o       (load),
    .bundle_o     (bundle)
  );

  nfrag_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .bundle_i     (bundle),
    .load_ok_o    (load_ok),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .is_header_o  (is_header_o),
    .packet_end_o (packet_end_o),
    .run_last_o   (run_last_o)
  );

endmodule
